// File: hw/rtl/dtba_pkg.sv
// ----------------------------------------------------------------------------
// Dual token-bucket admission package
// Shared types, field widths and constants for the admission block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtba_pkg;

   localparam int CALLER_SLOTS = 256;
   localparam int SLOT_W       = $clog2(CALLER_SLOTS);

   localparam int TS_W    = 48;  // millisecond timestamps
   localparam int COST_W  = 32;
   localparam int RLIM_W  = 16;
   localparam int BLIM_W  = 32;
   localparam int RTOK_W  = 32;  // rate tokens, x60000
   localparam int BTOK_W  = 54;  // budget tokens, x3600000
   localparam int RETRY_W = 32;
   localparam int IDLE_W  = 32;

   // Clipped time deltas: beyond these a bucket always refills to capacity.
   localparam int DT_R_W = 16;
   localparam int DT_B_W = 22;

   // Wait fractions: rate side and budget side numerator / denominator.
   localparam int RWN_W = 16;
   localparam int RWD_W = 26;
   localparam int BWN_W = 54;
   localparam int BWD_W = 42;

   localparam logic [RTOK_W-1:0] RATE_UNIT      = RTOK_W'(60000);
   localparam logic [BTOK_W-1:0] BUDGET_SCALE   = BTOK_W'(3600000);
   localparam logic [RWN_W-1:0]  NO_REFILL_WAIT = RWN_W'(3600);
   localparam int                MS_PER_S       = 1000;

   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = IDLE_W'(3600000);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_ENABLED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT_MS  = 1'd1;

   // Refusal reasons.
   localparam logic [1:0] REASON_NONE     = 2'd0;
   localparam logic [1:0] REASON_RATE     = 2'd1;
   localparam logic [1:0] REASON_BUDGET   = 2'd2;
   localparam logic [1:0] REASON_HOPELESS = 2'd3;

   typedef struct packed {
      logic [7:0]        caller_slot;
      logic [TS_W-1:0]   now_ms;
      logic [COST_W-1:0] cost;
      logic [RLIM_W-1:0] rate_limit;
      logic [BLIM_W-1:0] budget_limit;
      logic              has_own_limits;
   } req_type;

   typedef struct packed {
      logic               allowed;
      logic [RETRY_W-1:0] retry_secs;
      logic [1:0]         refusal_reason;
   } rsp_type;

   typedef struct packed {
      logic [RLIM_W-1:0] rate_cap;
      logic [BLIM_W-1:0] budget_cap;
      logic [RTOK_W-1:0] rate_tokens;
      logic [BTOK_W-1:0] budget_tokens;
      logic [TS_W-1:0]   rate_last;
      logic [TS_W-1:0]   budget_last;
      logic [TS_W-1:0]   seen_ms;
   } slot_entry_type;

endpackage

`default_nettype wire

// File: hw/rtl/dtba_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtba_slot_ram (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [dtba_pkg::SLOT_W-1:0]   rd_addr,
   output dtba_pkg::slot_entry_type           rd_data,
   input  wire logic                          wr_en,
   input  wire logic [dtba_pkg::SLOT_W-1:0]   wr_addr,
   input  wire dtba_pkg::slot_entry_type      wr_data
);

   dtba_pkg::slot_entry_type mem [dtba_pkg::CALLER_SLOTS];
   dtba_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dtba_frac_cmp.sv
// ----------------------------------------------------------------------------
// Wait fraction comparator
// Decides a_num/a_den > b_num/b_den by shift-and-add cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module dtba_frac_cmp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [dtba_pkg::BWN_W-1:0]  a_num,
   input  wire logic [dtba_pkg::BWD_W-1:0]  a_den,
   input  wire logic [dtba_pkg::RWN_W-1:0]  b_num,
   input  wire logic [dtba_pkg::RWD_W-1:0]  b_den,
   output logic                             done,
   output logic                             greater
);

   localparam int PA_W  = dtba_pkg::BWN_W + dtba_pkg::RWD_W;
   localparam int PB_W  = dtba_pkg::RWN_W + dtba_pkg::BWD_W;
   localparam int STEPS = dtba_pkg::RWD_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [PA_W-1:0]                acc_a_ff, mcand_a_ff;
   logic [PB_W-1:0]                acc_b_ff, mcand_b_ff;
   logic [dtba_pkg::RWD_W-1:0]     mplier_a_ff;
   logic [dtba_pkg::RWN_W-1:0]     mplier_b_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_a_ff    <= '0;
            acc_b_ff    <= '0;
            mcand_a_ff  <= PA_W'(a_num);
            mcand_b_ff  <= PB_W'(a_den);
            mplier_a_ff <= b_den;
            mplier_b_ff <= b_num;
            cnt_ff      <= CNT_W'(STEPS);
            busy_ff     <= 1'b1;
         end else if (busy_ff) begin
            if (mplier_a_ff[0]) acc_a_ff <= acc_a_ff + mcand_a_ff;
            if (mplier_b_ff[0]) acc_b_ff <= acc_b_ff + mcand_b_ff;
            mcand_a_ff  <= mcand_a_ff << 1;
            mcand_b_ff  <= mcand_b_ff << 1;
            mplier_a_ff <= mplier_a_ff >> 1;
            mplier_b_ff <= mplier_b_ff >> 1;
            cnt_ff      <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign greater = acc_a_ff > PA_W'(acc_b_ff);

endmodule

`default_nettype wire

// File: hw/rtl/dtba_divider.sv
// ----------------------------------------------------------------------------
// Retry divider
// Restoring divider, one quotient bit per cycle, with remainder flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dtba_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [dtba_pkg::BWN_W-1:0]  dividend,
   input  wire logic [dtba_pkg::BWD_W-1:0]  divisor,
   output logic                             done,
   output logic [dtba_pkg::BWN_W-1:0]       quotient,
   output logic                             rem_nonzero
);

   localparam int NW    = dtba_pkg::BWN_W;
   localparam int DW    = dtba_pkg::BWD_W;
   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    quo_ff;
   logic [DW-1:0]    rem_ff, div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DW:0]      shifted, diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
            cnt_ff  <= CNT_W'(NW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_ff <= {quo_ff[NW-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

`default_nettype wire

// File: hw/rtl/dual_token_bucket_admission_top.sv
// ----------------------------------------------------------------------------
// Dual token-bucket admission control
// Per-slot request-rate and compute-budget buckets held in a slot table.
// ----------------------------------------------------------------------------
// Each request on the req_ channel names a caller slot, a timestamp, a cost
// and the caller's limits. The block answers every request with exactly one
// response on the rsp_ channel: allowed, a refusal reason and a retry-after
// in seconds. Both channels use valid/stall; a request is taken when valid is
// high and stall is low.
// One request is processed at a time. A request that bypasses metering goes
// straight from idle to the done state, and the next request can be taken
// once the block is back in idle. A metered request reads its slot entry,
// refills and checks both buckets, and writes the entry back; an admission
// or a hopeless refusal passes through the read, delta, multiply, update,
// check, final and done states. A refusal with a retry time runs a 54-step
// serial division before the final state; when the budget bucket is short
// a 26-step cross-product comparison comes first. The serial units set the
// refusal rate.
// The response register lets the next request enter while an earlier response
// is stalled; the block then holds the new result in its done state until the
// register frees.
// Reset clears the slot valid bits at once, so no clearing pass is needed, and
// sets policy off with a one-hour idle limit. The user writes configuration
// through csr_we/csr_index/csr_wdata while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_token_bucket_admission_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire dtba_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output dtba_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [dtba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dtba_pkg::IDLE_W-1:0]     csr_wdata
);

   localparam int RT = dtba_pkg::RTOK_W;
   localparam int BT = dtba_pkg::BTOK_W;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_DT, S_MUL, S_UPD, S_CHECK, S_CMP, S_DIV, S_FINAL, S_DONE
   } state_type;

   state_type state_ff;

   logic                          policy_enabled_ff;
   logic [dtba_pkg::IDLE_W-1:0]   idle_limit_ff;
   logic                          slot_valid_ff [dtba_pkg::CALLER_SLOTS];

   dtba_pkg::req_type             req_ff;
   logic [dtba_pkg::SLOT_W-1:0]   slot_ff;
   logic [BT-1:0]                 need_b_ff;
   dtba_pkg::slot_entry_type      ent_ff;
   logic [RT-1:0]                 capr_ff, need_r_ff, prod_r_ff;
   logic [BT-1:0]                 capb_ff, need_bk_ff, prod_b_ff;
   logic [dtba_pkg::TS_W-1:0]     dtr_ff, dtb_ff;
   logic                          r_go_ff, b_go_ff, r_big_ff, b_big_ff, r_full_ff, b_full_ff;

   logic [dtba_pkg::RWN_W-1:0]    rwn_ff;
   logic [dtba_pkg::RWD_W-1:0]    rwd_ff;
   logic [dtba_pkg::BWN_W-1:0]    bn_ff;
   logic [dtba_pkg::BWD_W-1:0]    bd_ff;
   logic                          cmp_start_ff, div_start_ff;
   logic [dtba_pkg::BWN_W-1:0]    div_num_ff;
   logic [dtba_pkg::BWD_W-1:0]    div_den_ff;
   logic [1:0]                    reason_ff;

   dtba_pkg::rsp_type             res_ff, rsp_data_ff;
   logic                          rsp_valid_ff;

   dtba_pkg::slot_entry_type      rd_entry;
   logic                          cmp_done, cmp_greater, div_done, div_rnz;
   logic [dtba_pkg::BWN_W-1:0]    div_quo;

   logic                          req_accept, rsp_free;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // ---- Slot read stage: pick the stored entry or start the slot afresh ----
   logic          fresh;
   logic [RT-1:0] fr_capr, od_capr;
   logic [BT-1:0] fr_capb, od_capb;

   always_comb begin
      fresh = !slot_valid_ff[slot_ff] ||
              ((req_ff.now_ms > rd_entry.seen_ms) &&
               ((req_ff.now_ms - rd_entry.seen_ms) > dtba_pkg::TS_W'(idle_limit_ff)));
      fr_capr = RT'(req_ff.rate_limit) * dtba_pkg::RATE_UNIT;
      od_capr = RT'(rd_entry.rate_cap) * dtba_pkg::RATE_UNIT;
      fr_capb = BT'(req_ff.budget_limit) * dtba_pkg::BUDGET_SCALE;
      od_capb = BT'(rd_entry.budget_cap) * dtba_pkg::BUDGET_SCALE;
   end

   // ---- Refill: a bucket short of capacity gains dt * per_ms, capped ----
   logic [RT-1:0]             upd_rtok;
   logic [BT-1:0]             upd_btok;
   logic [dtba_pkg::TS_W-1:0] upd_rlast, upd_blast;

   always_comb begin
      upd_rtok  = ent_ff.rate_tokens;
      upd_rlast = ent_ff.rate_last;
      if (r_go_ff) begin
         upd_rlast = req_ff.now_ms;
         if (r_full_ff) begin
            upd_rtok = capr_ff;
         end else if (ent_ff.rate_cap != '0) begin
            upd_rtok = (r_big_ff || prod_r_ff > need_r_ff) ? capr_ff
                                                         : ent_ff.rate_tokens + prod_r_ff;
         end
      end
      upd_btok  = ent_ff.budget_tokens;
      upd_blast = ent_ff.budget_last;
      if (b_go_ff) begin
         upd_blast = req_ff.now_ms;
         if (b_full_ff) begin
            upd_btok = capb_ff;
         end else if (ent_ff.budget_cap != '0) begin
            upd_btok = (b_big_ff || prod_b_ff > need_bk_ff) ? capb_ff
                                                          : ent_ff.budget_tokens + prod_b_ff;
         end
      end
   end

   // ---- Check: which buckets are short, and their wait fractions ----
   logic                       r_short, b_short, hopeless;
   logic [dtba_pkg::RWN_W-1:0] rwn_c;
   logic [dtba_pkg::RWD_W-1:0] rwd_c;
   logic [dtba_pkg::BWN_W-1:0] bn_c;
   logic [dtba_pkg::BWD_W-1:0] bd_c;

   always_comb begin
      r_short = (req_ff.rate_limit != '0) && (ent_ff.rate_tokens < dtba_pkg::RATE_UNIT);
      b_short = (req_ff.budget_limit != '0) && (ent_ff.budget_tokens < need_b_ff);
      rwn_c   = '0;
      rwd_c   = dtba_pkg::RWD_W'(1);
      if (r_short) begin
         if (ent_ff.rate_cap == '0) begin
            rwn_c = dtba_pkg::NO_REFILL_WAIT;
         end else begin
            rwn_c = dtba_pkg::RWN_W'(dtba_pkg::RATE_UNIT - ent_ff.rate_tokens);
            rwd_c = dtba_pkg::RWD_W'(ent_ff.rate_cap) * dtba_pkg::RWD_W'(dtba_pkg::MS_PER_S);
         end
      end
      if (ent_ff.budget_cap == '0) begin
         bn_c = dtba_pkg::BWN_W'(dtba_pkg::NO_REFILL_WAIT);
         bd_c = dtba_pkg::BWD_W'(1);
      end else begin
         bn_c = need_b_ff - ent_ff.budget_tokens;
         bd_c = dtba_pkg::BWD_W'(ent_ff.budget_cap) * dtba_pkg::BWD_W'(dtba_pkg::MS_PER_S);
      end
      hopeless = b_short && (ent_ff.budget_cap != '0) &&
                 (req_ff.cost > ent_ff.budget_cap);
   end

   // Retry is the ceiling of the quotient, saturated to 32 bits.
   logic [dtba_pkg::BWN_W:0] retry_sum;
   assign retry_sum = {1'b0, div_quo} + (dtba_pkg::BWN_W + 1)'(div_rnz);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         policy_enabled_ff <= 1'b0;
         idle_limit_ff     <= dtba_pkg::IDLE_LIMIT_RESET;
         rsp_valid_ff      <= 1'b0;
         cmp_start_ff      <= 1'b0;
         div_start_ff      <= 1'b0;
         for (int i = 0; i < dtba_pkg::CALLER_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else begin
         cmp_start_ff <= 1'b0;
         div_start_ff <= 1'b0;

         if (csr_we) begin
            unique case (csr_index)
               dtba_pkg::CSR_POLICY_ENABLED: policy_enabled_ff <= csr_wdata[0];
               dtba_pkg::CSR_IDLE_LIMIT_MS:  idle_limit_ff     <= csr_wdata;
               default: ;
            endcase
         end

         // A finished result loads the response register once it is free;
         // otherwise an accepted response empties it.
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  req_ff    <= req_data;
                  slot_ff   <= req_data.caller_slot[dtba_pkg::SLOT_W-1:0];
                  need_b_ff <= BT'(req_data.cost) * dtba_pkg::BUDGET_SCALE;
                  res_ff    <= '{allowed: 1'b1, retry_secs: '0,
                                 refusal_reason: dtba_pkg::REASON_NONE};
                  // With policy off, requests without own limits pass untouched.
                  state_ff  <= (!policy_enabled_ff && !req_data.has_own_limits) ? S_DONE
                                                                                : S_READ;
               end
            end
            S_READ: begin
               if (fresh) begin
                  ent_ff <= '{rate_cap: req_ff.rate_limit, budget_cap: req_ff.budget_limit,
                              rate_tokens: fr_capr, budget_tokens: fr_capb,
                              rate_last: req_ff.now_ms, budget_last: req_ff.now_ms,
                              seen_ms: req_ff.now_ms};
                  capr_ff <= fr_capr;
                  capb_ff <= fr_capb;
               end else begin
                  ent_ff  <= '{rate_cap: rd_entry.rate_cap, budget_cap: rd_entry.budget_cap,
                               rate_tokens: rd_entry.rate_tokens,
                               budget_tokens: rd_entry.budget_tokens,
                               rate_last: rd_entry.rate_last,
                               budget_last: rd_entry.budget_last,
                               seen_ms: req_ff.now_ms};
                  capr_ff <= od_capr;
                  capb_ff <= od_capb;
               end
               state_ff <= S_DT;
            end
            S_DT: begin
               dtr_ff   <= req_ff.now_ms - ent_ff.rate_last;
               dtb_ff   <= req_ff.now_ms - ent_ff.budget_last;
               r_go_ff  <= (req_ff.rate_limit != '0) && (req_ff.now_ms > ent_ff.rate_last);
               b_go_ff  <= (req_ff.budget_limit != '0) && (req_ff.now_ms > ent_ff.budget_last);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               // The shortfall over per_ms never exceeds one full refill period,
               // so a delta past the clipped width always fills the bucket.
               prod_r_ff  <= RT'(dtr_ff[dtba_pkg::DT_R_W-1:0]) * RT'(ent_ff.rate_cap);
               prod_b_ff  <= BT'(dtb_ff[dtba_pkg::DT_B_W-1:0]) * BT'(ent_ff.budget_cap);
               r_big_ff   <= dtr_ff[dtba_pkg::TS_W-1:dtba_pkg::DT_R_W] != '0;
               b_big_ff   <= dtb_ff[dtba_pkg::TS_W-1:dtba_pkg::DT_B_W] != '0;
               need_r_ff  <= capr_ff - ent_ff.rate_tokens;
               need_bk_ff <= capb_ff - ent_ff.budget_tokens;
               r_full_ff  <= ent_ff.rate_tokens >= capr_ff;
               b_full_ff  <= ent_ff.budget_tokens >= capb_ff;
               state_ff   <= S_UPD;
            end
            S_UPD: begin
               ent_ff.rate_tokens   <= upd_rtok;
               ent_ff.rate_last     <= upd_rlast;
               ent_ff.budget_tokens <= upd_btok;
               ent_ff.budget_last   <= upd_blast;
               state_ff             <= S_CHECK;
            end
            S_CHECK: begin
               rwn_ff <= rwn_c;
               rwd_ff <= rwd_c;
               bn_ff  <= bn_c;
               bd_ff  <= bd_c;
               if (hopeless) begin
                  res_ff   <= '{allowed: 1'b0, retry_secs: '0,
                                refusal_reason: dtba_pkg::REASON_HOPELESS};
                  state_ff <= S_FINAL;
               end else if (b_short) begin
                  cmp_start_ff <= 1'b1;
                  state_ff     <= S_CMP;
               end else if (r_short) begin
                  div_num_ff   <= dtba_pkg::BWN_W'(rwn_c);
                  div_den_ff   <= dtba_pkg::BWD_W'(rwd_c);
                  reason_ff    <= dtba_pkg::REASON_RATE;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end else begin
                  // Both buckets hold enough: admit and debit.
                  if (req_ff.rate_limit != '0) begin
                     ent_ff.rate_tokens <= ent_ff.rate_tokens - dtba_pkg::RATE_UNIT;
                  end
                  if (req_ff.budget_limit != '0) begin
                     ent_ff.budget_tokens <= ent_ff.budget_tokens - need_b_ff;
                  end
                  state_ff <= S_FINAL;
               end
            end
            S_CMP: begin
               // The budget wait wins only when strictly longer than the rate wait.
               if (cmp_done) begin
                  if (cmp_greater) begin
                     div_num_ff <= bn_ff;
                     div_den_ff <= bd_ff;
                     reason_ff  <= dtba_pkg::REASON_BUDGET;
                  end else begin
                     div_num_ff <= dtba_pkg::BWN_W'(rwn_ff);
                     div_den_ff <= dtba_pkg::BWD_W'(rwd_ff);
                     reason_ff  <= dtba_pkg::REASON_RATE;
                  end
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  res_ff.allowed        <= 1'b0;
                  res_ff.refusal_reason <= reason_ff;
                  if (retry_sum[dtba_pkg::BWN_W:dtba_pkg::RETRY_W] != '0) begin
                     res_ff.retry_secs <= '1;
                  end else begin
                     res_ff.retry_secs <= retry_sum[dtba_pkg::RETRY_W-1:0];
                  end
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               slot_valid_ff[slot_ff] <= 1'b1;
               state_ff               <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dtba_slot_ram u_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (req_data.caller_slot[dtba_pkg::SLOT_W-1:0]),
      .rd_data (rd_entry),
      .wr_en   (state_ff == S_FINAL),
      .wr_addr (slot_ff),
      .wr_data (ent_ff)
   );

   dtba_frac_cmp u_cmp (
      .clock   (clock),
      .reset   (reset),
      .start   (cmp_start_ff),
      .a_num   (bn_ff),
      .a_den   (bd_ff),
      .b_num   (rwn_ff),
      .b_den   (rwd_ff),
      .done    (cmp_done),
      .greater (cmp_greater)
   );

   dtba_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start_ff),
      .dividend    (div_num_ff),
      .divisor     (div_den_ff),
      .done        (div_done),
      .quotient    (div_quo),
      .rem_nonzero (div_rnz)
   );

endmodule

`default_nettype wire

// File: hw/rtl/dtba_checker.sv
// ----------------------------------------------------------------------------
// Admission port checker
// Checks response consistency on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dtba_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire dtba_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_allowed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.allowed |->
         rsp_data.retry_secs == '0 &&
         rsp_data.refusal_reason == dtba_pkg::REASON_NONE)
      else $error("admitted response carries retry or reason");

   a_refused_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.allowed |->
         rsp_data.refusal_reason != dtba_pkg::REASON_NONE)
      else $error("refusal without reason");

   a_hopeless_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.refusal_reason == dtba_pkg::REASON_HOPELESS |->
         rsp_data.retry_secs == '0)
      else $error("hopeless refusal with retry time");

endmodule

bind dual_token_bucket_admission_top dtba_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
